>>> rtl/core/bipartite_label_relation_matrix_core_macros.svh
// assertion macros used by the checker file
`ifndef BIPARTITE_LABEL_RELATION_MATRIX_CORE_MACROS_SVH
`define BIPARTITE_LABEL_RELATION_MATRIX_CORE_MACROS_SVH

// same-cycle implication, disabled while dis is high
`define BLRM_ASSERT_IMP(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while dis is high
`define BLRM_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/blrm_pkg.sv
// package: shared types and constants of the label relation matrix core
package blrm_pkg;

  localparam int MAX_NODES_DEF  = 1024;
  localparam int MAX_GROUPS_DEF = 8;
  localparam int COUNT_BITS_DEF = 16;

  localparam int NODE_W  = 10;
  localparam int GROUP_W = 3;
  localparam int GC_W    = 4;
  localparam int IDX_W   = 3;
  localparam int PROB_W  = 17;
  localparam int MAT_W   = 48;
  localparam int SUM_W   = 51;
  localparam int PADDR_W = 3;

  localparam logic [GC_W-1:0]  GC_RESET = 4'd8;
  localparam logic [MAT_W-1:0] MAT_MAX  = '1;

  // register index decoded from paddr[2]
  localparam logic REG_GROUP_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_LOAD    = 2'd0,
    CMD_MARK    = 2'd1,
    CMD_EDGE    = 2'd2,
    CMD_COMPUTE = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                command;
    logic [NODE_W-1:0]   node_a;
    logic [NODE_W-1:0]   node_b;
    logic [GROUP_W-1:0]  seed_group;
  } cmd_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    logic [PROB_W-1:0]   probability;
    logic                last_entry;
  } res_item_t;

endpackage

>>> rtl/core/blrm_ram.sv
// generic single write port ram with registered read
module blrm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/bipartite_label_relation_matrix_core.sv
// top level: bipartite label relation matrix core
//
// Usage:
//  - cmd channel (valid/ready) takes one command transaction: load seed label,
//    mark node, edge, or compute. res channel (valid/ready) returns matrix
//    entries, row by row, only for compute; the last one has last_entry set.
//  - APB-style port holds group_count at byte address 0; write only when idle.
//  - Load and mark write their memory when accepted. An edge runs lookups of
//    mark and seed label, then a read-modify-write of the node's count row.
//  - Compute builds the matrix (one shared multiplier and saturating adder,
//    each matrix entry updated in a multiply state then an accumulate state),
//    then sends each entry through the shared 17-step divider; the receiver
//    can stall results by holding res_ready low.
//  - While a result waits on res_ready the block holds it and stays busy.
//  - After reset the block runs a clearing pass over every node of the
//    label, mark and count memories with cmd_ready low; config writes work.
//  - Reset sets group_count to 8 and drops all pending work.
module bipartite_label_relation_matrix_core #(
  parameter int MAX_NODES  = blrm_pkg::MAX_NODES_DEF,
  parameter int MAX_GROUPS = blrm_pkg::MAX_GROUPS_DEF,
  parameter int COUNT_BITS = blrm_pkg::COUNT_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [blrm_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         cmd_valid,
  output logic                         cmd_ready,
  input  blrm_pkg::cmd_item_t          cmd,
  output logic                         res_valid,
  input  logic                         res_ready,
  output blrm_pkg::res_item_t          res
);

  localparam int NODE_AW  = $clog2(MAX_NODES);
  localparam int NEXT_W   = ((NODE_AW > blrm_pkg::NODE_W) ? NODE_AW : blrm_pkg::NODE_W) + 1;
  localparam int GW       = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int MAT_AW   = 2 * GW;
  localparam int MAT_DEPTH = 1 << MAT_AW;
  localparam int ROW_W    = MAX_GROUPS * COUNT_BITS;
  localparam int PROD_W   = 2 * COUNT_BITS;
  localparam int ACC_W    = ((PROD_W > blrm_pkg::MAT_W) ? PROD_W : blrm_pkg::MAT_W) + 1;
  localparam int REM_W    = blrm_pkg::SUM_W + 1;
  localparam int STEP_W   = $clog2(blrm_pkg::PROB_W + 1);
  localparam int GC_W     = blrm_pkg::GC_W;
  localparam int MAT_W    = blrm_pkg::MAT_W;
  localparam int SUM_W    = blrm_pkg::SUM_W;
  localparam int PROB_W   = blrm_pkg::PROB_W;
  localparam int IDX_W    = blrm_pkg::IDX_W;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_E_CHK, S_E_SB, S_E_CNT, S_M_CLR, S_A_RD, S_A_MUL,
    S_A_ACC, S_C_RD, S_C_ACC, S_D_RD, S_D_LD, S_D_DIV, S_D_OUT
  } state_t;

  state_t                 state;
  logic [GC_W-1:0]        group_count;
  logic [NODE_AW-1:0]     node;
  logic [NODE_AW-1:0]     a_r;
  logic [NODE_AW-1:0]     b_r;
  logic [NODE_AW-1:0]     tgt_r;
  logic [GW-1:0]          lab_r;
  logic [GW-1:0]          j;
  logic [GW-1:0]          k;
  logic [PROD_W-1:0]      prod_r;
  logic [SUM_W-1:0]       colsum [MAX_GROUPS];
  logic [REM_W-1:0]       rem;
  logic [SUM_W-1:0]       div_r;
  logic [PROB_W-1:0]      quo;
  logic [STEP_W-1:0]      step;
  logic                   res_valid_r;
  blrm_pkg::res_item_t    res_r;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready &&
                  (paddr[2] == blrm_pkg::REG_GROUP_COUNT);
  assign prdata = (paddr[2] == blrm_pkg::REG_GROUP_COUNT) ? 32'(group_count) : '0;

  // effective group count
  logic [GC_W-1:0] g_eff;
  logic [GC_W-1:0] g_last;
  always_comb begin
    if (group_count == '0) begin
      g_eff = GC_W'(1);
    end else if (group_count > GC_W'(MAX_GROUPS)) begin
      g_eff = GC_W'(MAX_GROUPS);
    end else begin
      g_eff = group_count;
    end
    g_last = g_eff - 1'b1;
  end

  // input node decode and range checks
  logic [NEXT_W-1:0]  a_ext;
  logic [NEXT_W-1:0]  b_ext;
  logic               a_ok;
  logic               b_ok;
  logic [NODE_AW-1:0] a_in;
  logic [NODE_AW-1:0] b_in;
  logic               accept;
  assign a_ext  = NEXT_W'(cmd.node_a);
  assign b_ext  = NEXT_W'(cmd.node_b);
  assign a_ok   = a_ext < NEXT_W'(MAX_NODES);
  assign b_ok   = b_ext < NEXT_W'(MAX_NODES);
  assign a_in   = a_ext[NODE_AW-1:0];
  assign b_in   = b_ext[NODE_AW-1:0];
  assign accept = cmd_valid && cmd_ready;
  assign cmd_ready = (state == S_IDLE);

  // row/column walk over the g x g matrix
  logic k_end;
  logic j_end;
  logic jk_done;
  logic node_end;
  assign k_end    = (GC_W'(k) == g_last);
  assign j_end    = (GC_W'(j) == g_last);
  assign jk_done  = k_end && j_end;
  assign node_end = (node == NODE_AW'(MAX_NODES - 1));

  // memories
  logic                   seed_we;
  logic [NODE_AW-1:0]     seed_waddr;
  logic [3:0]             seed_wdata;
  logic [NODE_AW-1:0]     seed_raddr;
  logic [3:0]             seed_rd;
  logic                   mark_we;
  logic [0:0]             mark_wdata;
  logic [0:0]             mark_rd;
  logic                   cnt_we;
  logic [NODE_AW-1:0]     cnt_waddr;
  logic [ROW_W-1:0]       cnt_wdata;
  logic [NODE_AW-1:0]     cnt_raddr;
  logic [ROW_W-1:0]       cnt_rd;
  logic                   mat_we;
  logic [MAT_W-1:0]       mat_wdata;
  logic [MAT_AW-1:0]      mat_addr;
  logic [MAT_W-1:0]       mat_rd;

  // edge bump of one count and saturating matrix accumulate
  logic [COUNT_BITS-1:0]  cur_cnt;
  logic [ROW_W-1:0]       bump_row;
  logic [COUNT_BITS-1:0]  cj;
  logic [COUNT_BITS-1:0]  op;
  logic [ACC_W-1:0]       acc_sum;
  logic [MAT_W-1:0]       acc_sat;
  always_comb begin
    cur_cnt  = cnt_rd[lab_r*COUNT_BITS +: COUNT_BITS];
    bump_row = cnt_rd;
    if (cur_cnt != '1) begin
      bump_row[lab_r*COUNT_BITS +: COUNT_BITS] = cur_cnt + 1'b1;
    end
    cj = cnt_rd[j*COUNT_BITS +: COUNT_BITS];
    op = (j == k) ? (cj - 1'b1) : cnt_rd[k*COUNT_BITS +: COUNT_BITS];
    acc_sum = ACC_W'(mat_rd) + ACC_W'(prod_r);
    acc_sat = (acc_sum > ACC_W'(blrm_pkg::MAT_MAX)) ? blrm_pkg::MAT_MAX
                                                     : acc_sum[MAT_W-1:0];
  end

  // seed label checks
  logic seed_ok;
  assign seed_ok = seed_rd[3] && ({1'b0, seed_rd[2:0]} < g_eff);

  // memory port control
  logic clearing;
  assign clearing = (state == S_CLEAR);
  always_comb begin
    seed_we    = clearing || (accept && (cmd.command == blrm_pkg::CMD_LOAD) && a_ok);
    seed_waddr = clearing ? node : a_in;
    seed_wdata = clearing ? 4'd0 : {1'b1, cmd.seed_group};
    seed_raddr = (state == S_E_CHK) ? b_r : a_in;
    mark_we    = clearing || (accept && (cmd.command == blrm_pkg::CMD_MARK) && a_ok);
    mark_wdata = clearing ? 1'b0 : 1'b1;
    cnt_we     = clearing || (state == S_E_CNT);
    cnt_waddr  = clearing ? node : tgt_r;
    cnt_wdata  = clearing ? '0 : bump_row;
    case (state)
      S_E_CHK: cnt_raddr = b_r;
      S_E_SB:  cnt_raddr = a_r;
      default: cnt_raddr = node;
    endcase
    mat_we    = (state == S_M_CLR) || (state == S_A_ACC);
    mat_wdata = (state == S_M_CLR) ? '0 : acc_sat;
    mat_addr  = {j, k};
  end

  blrm_ram #(.WIDTH(4), .DEPTH(MAX_NODES)) u_seed_ram (
    .clk(clk), .we(seed_we), .waddr(seed_waddr), .wdata(seed_wdata),
    .raddr(seed_raddr), .rdata(seed_rd)
  );

  blrm_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_mark_ram (
    .clk(clk), .we(mark_we), .waddr(seed_waddr), .wdata(mark_wdata),
    .raddr(a_in), .rdata(mark_rd)
  );

  blrm_ram #(.WIDTH(ROW_W), .DEPTH(MAX_NODES)) u_count_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(cnt_raddr), .rdata(cnt_rd)
  );

  blrm_ram #(.WIDTH(MAT_W), .DEPTH(MAT_DEPTH)) u_matrix_ram (
    .clk(clk), .we(mat_we), .waddr(mat_addr), .wdata(mat_wdata),
    .raddr(mat_addr), .rdata(mat_rd)
  );

  // divider step: restoring, one quotient bit per cycle
  logic [REM_W-1:0]  div_t;
  logic              div_bit;
  logic [PROB_W-1:0] quo_next;
  always_comb begin
    div_t    = (step == '0) ? rem : {rem[REM_W-2:0], 1'b0};
    div_bit  = div_t >= REM_W'(div_r);
    quo_next = {quo[PROB_W-2:0], div_bit};
  end

  // sequencer with registered outputs
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      group_count <= blrm_pkg::GC_RESET;
      node        <= '0;
      j           <= '0;
      k           <= '0;
      res_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        group_count <= pwdata[GC_W-1:0];
      end
      case (state)
        S_CLEAR: begin
          if (node_end) begin
            node  <= '0;
            state <= S_IDLE;
          end else begin
            node <= node + 1'b1;
          end
        end
        S_IDLE: begin
          a_r <= a_in;
          b_r <= b_in;
          j   <= '0;
          k   <= '0;
          if (accept) begin
            case (cmd.command)
              blrm_pkg::CMD_EDGE: begin
                if (a_ok && b_ok) begin
                  state <= S_E_CHK;
                end
              end
              blrm_pkg::CMD_COMPUTE: begin
                for (int i = 0; i < MAX_GROUPS; i++) begin
                  colsum[i] <= '0;
                end
                state <= S_M_CLR;
              end
              default: begin
              end
            endcase
          end
        end
        S_E_CHK: begin
          lab_r <= seed_rd[GW-1:0];
          tgt_r <= b_r;
          if (!mark_rd[0]) begin
            state <= S_E_SB;
          end else if (seed_ok) begin
            state <= S_E_CNT;
          end else begin
            state <= S_IDLE;
          end
        end
        S_E_SB: begin
          lab_r <= seed_rd[GW-1:0];
          tgt_r <= a_r;
          state <= seed_ok ? S_E_CNT : S_IDLE;
        end
        S_E_CNT: begin
          state <= S_IDLE;
        end
        S_M_CLR: begin
          k <= k_end ? '0 : k + 1'b1;
          if (jk_done) begin
            j     <= '0;
            node  <= '0;
            state <= (g_last == '0) ? S_C_RD : S_A_RD;
          end else if (k_end) begin
            j <= j + 1'b1;
          end
        end
        S_A_RD: begin
          state <= S_A_MUL;
        end
        S_A_MUL: begin
          prod_r <= cj * op;
          state  <= S_A_ACC;
        end
        S_A_ACC: begin
          k <= k_end ? '0 : k + 1'b1;
          if (jk_done) begin
            j     <= '0;
            node  <= node + 1'b1;
            state <= node_end ? S_C_RD : S_A_RD;
          end else begin
            state <= S_A_MUL;
            if (k_end) begin
              j <= j + 1'b1;
            end
          end
        end
        S_C_RD: begin
          state <= S_C_ACC;
        end
        S_C_ACC: begin
          colsum[k] <= colsum[k] + SUM_W'(mat_rd);
          k <= k_end ? '0 : k + 1'b1;
          if (jk_done) begin
            j     <= '0;
            state <= S_D_RD;
          end else begin
            state <= S_C_RD;
            if (k_end) begin
              j <= j + 1'b1;
            end
          end
        end
        S_D_RD: begin
          state <= S_D_LD;
        end
        S_D_LD: begin
          rem   <= REM_W'(mat_rd);
          div_r <= colsum[k];
          quo   <= '0;
          step  <= '0;
          state <= S_D_DIV;
        end
        S_D_DIV: begin
          rem  <= div_bit ? (div_t - REM_W'(div_r)) : div_t;
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == STEP_W'(PROB_W - 1)) begin
            res_r.row_index   <= IDX_W'(j);
            res_r.col_index   <= IDX_W'(k);
            res_r.probability <= (div_r == '0) ? '0 : quo_next;
            res_r.last_entry  <= jk_done;
            res_valid_r       <= 1'b1;
            state             <= S_D_OUT;
          end
        end
        S_D_OUT: begin
          if (res_ready) begin
            res_valid_r <= 1'b0;
            k           <= k_end ? '0 : k + 1'b1;
            if (jk_done) begin
              j     <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_D_RD;
              if (k_end) begin
                j <= j + 1'b1;
              end
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign res_valid = res_valid_r;
  assign res       = res_r;

endmodule

>>> rtl/core/blrm_checker.sv
// checker: port-level assertions of the core and its bind
`include "bipartite_label_relation_matrix_core_macros.svh"

module blrm_checker (
  input logic                clk,
  input logic                rst,
  input logic                cmd_ready,
  input logic                res_valid,
  input logic                res_ready,
  input blrm_pkg::res_item_t res
);

  // a stalled result holds
  `BLRM_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res))

  // no new command while a result is pending
  `BLRM_ASSERT_IMP(a_busy_out, clk, rst, res_valid, !cmd_ready)

  // clearing pass right after reset keeps the command channel closed
  `BLRM_ASSERT_IMP(a_clear_pass, clk, 1'b0, $fell(rst), !cmd_ready)

  // the run ends after its last entry
  `BLRM_ASSERT_NEXT(a_run_end, clk, rst, res_valid && res_ready && res.last_entry, !res_valid)

  // normalized values never exceed one
  `BLRM_ASSERT_IMP(a_prob_range, clk, rst, res_valid, res.probability <= 17'd65536)

endmodule

bind bipartite_label_relation_matrix_core blrm_checker u_blrm_checker (
  .clk(clk),
  .rst(rst),
  .cmd_ready(cmd_ready),
  .res_valid(res_valid),
  .res_ready(res_ready),
  .res(res)
);

>>> sim/bipartite_label_relation_matrix_core_test.sv
// testbench for the label relation matrix core: queued driver, monitor, predictor
module bipartite_label_relation_matrix_core_test;

  localparam int NODES = 1024;
  localparam int WATCH_LIMIT = 400000;
  localparam logic [63:0] COUNT_SAT = 64'd65535;
  localparam logic [63:0] MAT_SAT = (64'd1 << 48) - 64'd1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [blrm_pkg::PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic cmd_valid = 1'b0;
  logic cmd_ready;
  blrm_pkg::cmd_item_t cmd = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  blrm_pkg::res_item_t res;

  bipartite_label_relation_matrix_core u_dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
    .res_valid(res_valid), .res_ready(res_ready), .res(res)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // predictor state
  logic [3:0] group_reg = blrm_pkg::GC_RESET;
  logic seed_ok [NODES];
  logic [2:0] seed_lbl [NODES];
  logic marked [NODES];
  logic [15:0] node_counts [NODES][8];
  blrm_pkg::res_item_t entry_q[$];
  blrm_pkg::cmd_item_t pending_q[$];

  int errors = 0;
  int send_hold = 0;
  int hold_req = 0;
  int hold_done = 0;

  function automatic int active_groups();
    if (group_reg < 1) return 1;
    if (group_reg > 8) return 8;
    return int'(group_reg);
  endfunction

  function automatic void bump_count(int node, int lbl);
    if (64'(node_counts[node][lbl]) < COUNT_SAT) node_counts[node][lbl]++;
  endfunction

  // build the pair matrix and queue all normalized entries
  function automatic void emit_matrix(int g);
    logic [63:0] mat [8][8];
    logic [63:0] cj, p, s, colsum, v;
    blrm_pkg::res_item_t e;
    for (int j = 0; j < 8; j++)
      for (int k = 0; k < 8; k++) mat[j][k] = '0;
    if (g > 1) begin
      for (int n = 0; n < NODES; n++)
        for (int j = 0; j < g; j++) begin
          cj = 64'(node_counts[n][j]);
          for (int k = 0; k < g; k++) begin
            if (j == k) p = (cj > 0) ? cj * (cj - 1) : 64'd0;
            else p = cj * 64'(node_counts[n][k]);
            s = mat[j][k] + p;
            mat[j][k] = (s < mat[j][k] || s > MAT_SAT) ? MAT_SAT : s;
          end
        end
    end
    for (int j = 0; j < g; j++)
      for (int k = 0; k < g; k++) begin
        colsum = '0;
        for (int r = 0; r < g; r++) colsum += mat[r][k];
        v = (colsum > 0) ? (mat[j][k] << 16) / colsum : 64'd0;
        e.row_index = 3'(j);
        e.col_index = 3'(k);
        e.probability = v[16:0];
        e.last_entry = (j == g - 1 && k == g - 1);
        entry_q.push_back(e);
      end
  endfunction

  function automatic void apply_command(blrm_pkg::cmd_item_t c);
    int g;
    int a;
    int b;
    g = active_groups();
    a = int'(c.node_a);
    b = int'(c.node_b);
    case (c.command)
      blrm_pkg::CMD_LOAD: begin
        seed_ok[a] = 1'b1;
        seed_lbl[a] = c.seed_group;
      end
      blrm_pkg::CMD_MARK: marked[a] = 1'b1;
      blrm_pkg::CMD_EDGE: begin
        if (!marked[a]) begin
          if (seed_ok[b] && int'(seed_lbl[b]) < g) bump_count(a, int'(seed_lbl[b]));
        end else begin
          if (seed_ok[a] && int'(seed_lbl[a]) < g) bump_count(b, int'(seed_lbl[a]));
        end
      end
      default: emit_matrix(g);
    endcase
  endfunction

  initial begin
    for (int n = 0; n < NODES; n++) begin
      seed_ok[n] = 1'b0;
      seed_lbl[n] = '0;
      marked[n] = 1'b0;
      for (int k = 0; k < 8; k++) node_counts[n][k] = '0;
    end
  end

  // driver: bursts with random gaps, pauses on request until results drain
  int burst_left = 4;
  int gap_left = 0;
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (!(cmd_valid && !cmd_ready)) begin
      if (gap_left > 0) begin
        gap_left--;
        cmd_valid <= 1'b0;
      end else if (pending_q.size() > 0 && (send_hold == 0 || entry_q.size() == 0)) begin
        cmd <= pending_q.pop_front();
        cmd_valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        cmd_valid <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern plus an occasional long hold
  int rx_cycle = 0;
  int hold_cnt = 0;
  always @(posedge clk) begin
    rx_cycle++;
    if (rst) begin
      res_ready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      res_ready <= 1'b0;
    end else if (hold_req != hold_done && res_valid) begin
      hold_done++;
      hold_cnt = 3000;
      res_ready <= 1'b0;
    end else begin
      case ((rx_cycle / 150) % 4)
        0: res_ready <= 1'b1;
        1: res_ready <= ($urandom_range(0, 1) == 1);
        2: res_ready <= ($urandom_range(0, 7) != 0);
        default: res_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // monitor: predict on accepted commands, check accepted results
  blrm_pkg::res_item_t want;
  always @(posedge clk) begin
    if (!rst) begin
      if (cmd_valid && cmd_ready) apply_command(cmd);
      if (res_valid && res_ready) begin
        if (entry_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result row %0d col %0d prob %0d last %0b",
                                     res.row_index, res.col_index, res.probability,
                                     res.last_entry);
        end else begin
          want = entry_q.pop_front();
          if (res !== want) begin
            errors++;
            if (errors <= 10)
              $display("mismatch exp r%0d c%0d p%0d l%0b got r%0d c%0d p%0d l%0b",
                       want.row_index, want.col_index, want.probability, want.last_entry,
                       res.row_index, res.col_index, res.probability, res.last_entry);
          end
        end
      end
    end
  end

  // watchdog on cycles with no transaction
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready) || rst) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("FAIL bipartite_label_relation_matrix_core");
      $finish;
    end
  end

  function automatic blrm_pkg::cmd_item_t make_cmd(blrm_pkg::cmd_t op, int a, int b,
                                                   int lbl);
    blrm_pkg::cmd_item_t c;
    c.command = op;
    c.node_a = blrm_pkg::NODE_W'(a);
    c.node_b = blrm_pkg::NODE_W'(b);
    c.seed_group = blrm_pkg::GROUP_W'(lbl);
    return c;
  endfunction

  // mostly well-formed traffic on a small node pool, some noise
  function automatic blrm_pkg::cmd_item_t random_cmd(int base);
    int r;
    int a;
    int b;
    r = $urandom_range(0, 99);
    if (r < 10)
      return make_cmd(blrm_pkg::cmd_t'($urandom_range(0, 2)), $urandom_range(0, 1023),
                      $urandom_range(0, 1023), $urandom_range(0, 7));
    a = (base + $urandom_range(0, 15)) % NODES;
    b = (base + $urandom_range(0, 15)) % NODES;
    if (r < 35)
      return make_cmd(blrm_pkg::CMD_LOAD, a, $urandom_range(0, 1023), $urandom_range(0, 7));
    if (r < 47)
      return make_cmd(blrm_pkg::CMD_MARK, a, $urandom_range(0, 1023), $urandom_range(0, 7));
    return make_cmd(blrm_pkg::CMD_EDGE, a, b, $urandom_range(0, 7));
  endfunction

  task automatic wait_idle();
    while (pending_q.size() > 0 || cmd_valid || entry_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_group_count(logic [3:0] v);
    @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= '0;
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    group_reg = v;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_phase(logic [3:0] gc, int count, bit long_hold);
    int base;
    write_group_count(gc);
    base = $urandom_range(0, 1023);
    for (int i = 0; i < count; i++) pending_q.push_back(random_cmd(base));
    if (long_hold) hold_req++;
    pending_q.push_back(make_cmd(blrm_pkg::CMD_COMPUTE, $urandom, $urandom, $urandom));
    if (long_hold || send_hold != 0)
      for (int i = 0; i < 20; i++) pending_q.push_back(random_cmd(base));
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed part at reset group count of eight
    pending_q.push_back(make_cmd(blrm_pkg::CMD_LOAD, 0, 1023, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_LOAD, 1023, 0, 7));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_LOAD, 5, 0, 1));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_LOAD, 5, 0, 2));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_MARK, 1023, 0, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_MARK, 10, 1023, 7));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 3, 0, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 3, 0, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 3, 5, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 3, 1023, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 1023, 4, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 1023, 3, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 10, 3, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 6, 1023, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 6, 0, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 6, 5, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_EDGE, 7, 7, 0));
    pending_q.push_back(make_cmd(blrm_pkg::CMD_COMPUTE, 1023, 1023, 7));
    wait_idle();
    // random phases across group counts, extremes and out-of-range codes
    random_phase(4'd2, 20, 1'b0);
    random_phase(4'd1, 10, 1'b0);
    random_phase(4'd3, 30, 1'b1);
    random_phase(4'd0, 10, 1'b0);
    // sender pauses after compute until every result has come back
    send_hold = 1;
    random_phase(4'd4, 10, 1'b0);
    send_hold = 0;
    wait_idle();
    random_phase(4'd15, 20, 1'b0);
    repeat (50) @(posedge clk);
    if (errors == 0 && entry_q.size() == 0) begin
      $display("PASS bipartite_label_relation_matrix_core");
    end else begin
      $display("FAIL bipartite_label_relation_matrix_core");
    end
    $finish;
  end

endmodule
